@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define BAMS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Consequent holds in the cycle after the antecedent.
`define BAMS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ hw/rtl/bams_pkg.sv @@
// Shared types and constants of the block-average mean and standard error unit.
// No dependencies.
`default_nettype none
package bams_pkg;
	localparam int PosW    = 16;
	localparam int ResW    = 16;
	localparam int StepOutW = 6;
	localparam int CfgW    = 16;
	localparam int CfgIdxW = 2;

	localparam logic [CfgIdxW-1:0] CFG_STEPS  = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_THROWS = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_BLOCKS = 2'd2;

	typedef struct packed {
		logic rd_sample;
		logic commit;
		logic ent_clr;
		logic ent_inc;
		logic rd_ent;
		logic div_blk;
		logic div_mean;
		logic div_var;
		logic sq_start;
		logic blk_upd;
		logic blk_wr;
		logic mul1;
		logic mul2;
		logic se_zero;
		logic se_load;
		logic out_load;
		logic clr_sums;
		logic clr_tots;
	} bams_cmd_t;

	typedef struct packed {
		logic walk_end;
		logic block_end;
		logic run_end;
		logic ent_max;
		logic ent_steps;
		logic div_busy;
		logic sq_busy;
		logic var_pos;
		logic out_free;
	} bams_sts_t;
endpackage
`default_nettype wire

@@ hw/rtl/bams_sample_if.sv @@
// Request channel carrying one walk sample.
// Depends on bams_pkg.
`default_nettype none
interface bams_sample_if;
	logic valid;
	logic ready;
	logic [bams_pkg::PosW-1:0] position;
	modport source (output valid, output position, input ready);
	modport sink (input valid, input position, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/bams_result_if.sv @@
// Request channel carrying one per-step result.
// Depends on bams_pkg.
`default_nettype none
interface bams_result_if;
	logic valid;
	logic ready;
	logic [bams_pkg::StepOutW-1:0] step_index;
	logic [bams_pkg::ResW-1:0] mean_value;
	logic [bams_pkg::ResW-1:0] std_error;
	logic last_result;
	modport source (output valid, output step_index, output mean_value,
		output std_error, output last_result, input ready);
	modport sink (input valid, input step_index, input mean_value,
		input std_error, input last_result, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/bams_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module bams_ram #(
	parameter int W = 32,
	parameter int D = 64
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [$clog2(D)-1:0] waddr,
	input  wire logic [W-1:0]         wdata,
	input  wire logic [$clog2(D)-1:0] raddr,
	output logic      [W-1:0]         rdata
);
	logic [W-1:0] mem [D];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

@@ hw/rtl/bams_div.sv @@
// Restoring radix-2 divider, 64-bit dividend by 48-bit divisor, one bit per cycle.
// No dependencies.
`default_nettype none
module bams_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] dividend,
	input  wire logic [47:0] divisor,
	output logic             busy,
	output logic [63:0]      quotient
);
	logic        busy_q;
	logic [6:0]  cnt_q;
	logic [63:0] quo_q;
	logic [47:0] rem_q;
	logic [47:0] dvs_q;
	logic [48:0] shifted;
	logic        ge;

	assign shifted = {rem_q, quo_q[63]};
	assign ge      = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 7'd64;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 7'd1;
			if (cnt_q == 7'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[62:0], ge};
			rem_q <= ge ? 48'(shifted - {1'b0, dvs_q}) : shifted[47:0];
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;
endmodule
`default_nettype wire

@@ hw/rtl/bams_sqrt.sv @@
// Digit-by-digit integer square root of a 64-bit value, two radicand bits per cycle.
// No dependencies.
`default_nettype none
module bams_sqrt (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] radicand,
	output logic             busy,
	output logic [31:0]      root
);
	logic        busy_q;
	logic [5:0]  cnt_q;
	logic [63:0] rad_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;
	logic [35:0] shifted;
	logic [35:0] trial;
	logic        ge;

	assign shifted = {rem_q, rad_q[63:62]};
	assign trial   = {2'b00, root_q, 2'b01};
	assign ge      = shifted >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 6'd32;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[61:0], 2'b00};
			rem_q  <= ge ? 34'(shifted - trial) : shifted[33:0];
			root_q <= {root_q[30:0], ge};
		end
	end

	assign busy = busy_q;
	assign root = root_q;
endmodule
`default_nettype wire

@@ hw/rtl/bams_ctrl.sv @@
// Controller state machine: sample update, block close pass and final result pass.
// Depends on bams_pkg.
`default_nettype none
module bams_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                sample_valid,
	output logic                     sample_ready,
	input  wire bams_pkg::bams_sts_t sts,
	output bams_pkg::bams_cmd_t      cmd
);
	import bams_pkg::*;

	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_ADD  = 5'd1;
	localparam logic [4:0] CL_RD   = 5'd2;
	localparam logic [4:0] CL_LD   = 5'd3;
	localparam logic [4:0] CL_DIV  = 5'd4;
	localparam logic [4:0] CL_UPD  = 5'd5;
	localparam logic [4:0] CL_WR   = 5'd6;
	localparam logic [4:0] FN_RD   = 5'd7;
	localparam logic [4:0] FN_LD   = 5'd8;
	localparam logic [4:0] FN_DIV  = 5'd9;
	localparam logic [4:0] FN_MUL  = 5'd10;
	localparam logic [4:0] FN_MUL2 = 5'd11;
	localparam logic [4:0] FN_CMP  = 5'd12;
	localparam logic [4:0] FN_DIV2 = 5'd13;
	localparam logic [4:0] FN_SQS  = 5'd14;
	localparam logic [4:0] FN_SQ   = 5'd15;
	localparam logic [4:0] FN_OUT  = 5'd16;

	logic [4:0] state_q;
	logic [4:0] state_nx;
	logic       run_pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			run_pend_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_ADD) begin
				run_pend_q <= sts.walk_end && sts.block_end && sts.run_end;
			end
		end
	end

	assign sample_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (sample_valid) begin
					cmd.rd_sample = 1'b1;
					state_nx      = ST_ADD;
				end
			end
			ST_ADD: begin
				cmd.commit = 1'b1;
				if (sts.walk_end && sts.block_end) begin
					cmd.ent_clr = 1'b1;
					state_nx    = CL_RD;
				end else begin
					state_nx = ST_IDLE;
				end
			end
			CL_RD: begin
				cmd.rd_ent = 1'b1;
				state_nx   = CL_LD;
			end
			CL_LD: begin
				cmd.div_blk = 1'b1;
				state_nx    = CL_DIV;
			end
			CL_DIV: begin
				if (!sts.div_busy) begin
					state_nx = CL_UPD;
				end
			end
			CL_UPD: begin
				cmd.blk_upd = 1'b1;
				state_nx    = CL_WR;
			end
			CL_WR: begin
				cmd.blk_wr = 1'b1;
				if (sts.ent_max) begin
					cmd.clr_sums = 1'b1;
					if (run_pend_q) begin
						cmd.ent_clr = 1'b1;
						state_nx    = FN_RD;
					end else begin
						state_nx = ST_IDLE;
					end
				end else begin
					cmd.ent_inc = 1'b1;
					state_nx    = CL_RD;
				end
			end
			FN_RD: begin
				cmd.rd_ent = 1'b1;
				state_nx   = FN_LD;
			end
			FN_LD: begin
				cmd.div_mean = 1'b1;
				state_nx     = FN_DIV;
			end
			FN_DIV: begin
				if (!sts.div_busy) begin
					state_nx = FN_MUL;
				end
			end
			FN_MUL: begin
				cmd.mul1 = 1'b1;
				state_nx = FN_MUL2;
			end
			FN_MUL2: begin
				cmd.mul2 = 1'b1;
				state_nx = FN_CMP;
			end
			FN_CMP: begin
				if (sts.var_pos) begin
					cmd.div_var = 1'b1;
					state_nx    = FN_DIV2;
				end else begin
					cmd.se_zero = 1'b1;
					state_nx    = FN_OUT;
				end
			end
			FN_DIV2: begin
				if (!sts.div_busy) begin
					state_nx = FN_SQS;
				end
			end
			FN_SQS: begin
				cmd.sq_start = 1'b1;
				state_nx     = FN_SQ;
			end
			FN_SQ: begin
				if (!sts.sq_busy) begin
					cmd.se_load = 1'b1;
					state_nx    = FN_OUT;
				end
			end
			FN_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					if (sts.ent_steps) begin
						cmd.clr_tots = 1'b1;
						state_nx     = ST_IDLE;
					end else begin
						cmd.ent_inc = 1'b1;
						state_nx    = FN_RD;
					end
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end
endmodule
`default_nettype wire

@@ hw/rtl/bams_dp.sv @@
// Datapath: configuration, counters, per-step stores, arithmetic units, result register.
// Depends on bams_pkg, bams_ram, bams_div and bams_sqrt.
`default_nettype none
module bams_dp #(
	parameter int MAX_STEPS = 64
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [bams_pkg::CfgIdxW-1:0]    cfg_index,
	input  wire logic [bams_pkg::CfgW-1:0]       cfg_data,
	input  wire logic [bams_pkg::PosW-1:0]       position,
	input  wire logic                            res_ready,
	output logic                                 res_valid,
	output logic [bams_pkg::StepOutW-1:0]        res_step_index,
	output logic [bams_pkg::ResW-1:0]            res_mean_value,
	output logic [bams_pkg::ResW-1:0]            res_std_error,
	output logic                                 res_last_result,
	input  wire bams_pkg::bams_cmd_t             cmd,
	output bams_pkg::bams_sts_t                  sts
);
	import bams_pkg::*;

	localparam int IW = $clog2(MAX_STEPS);

	logic [6:0]  steps_q;
	logic [15:0] throws_q;
	logic [15:0] blocks_q;
	logic [6:0]  steps_eff;
	logic [15:0] throws_eff;
	logic [15:0] n_eff;

	logic [5:0]  step_cnt_q;
	logic [15:0] throw_cnt_q;
	logic [15:0] block_cnt_q;
	logic        walk_end;
	logic        block_end;
	logic        run_end;

	logic [IW-1:0] idx;
	logic [IW-1:0] idx_q;
	logic [IW-1:0] ent_q;
	logic [IW-1:0] rd_addr;
	logic [PosW-1:0] pos_q;

	logic [MAX_STEPS-1:0] sum_vld_q;
	logic [MAX_STEPS-1:0] tot_vld_q;
	logic                 sum_rv_s1;
	logic                 tot_rv_s1;
	logic [31:0] sum_rdata;
	logic [31:0] mt_rdata;
	logic [47:0] sq_rdata;
	logic [31:0] sum_eff;
	logic [31:0] mt_eff;
	logic [47:0] sq_eff;

	logic [31:0] mt_q;
	logic [47:0] sq_q;
	logic [31:0] bmsq_q;
	logic [15:0] bm;
	logic [15:0] mean_q;
	logic [15:0] se_q;
	logic [39:0] p0_s1;
	logic [39:0] p1_s1;
	logic [63:0] bsq_s1;
	logic [31:0] nn_s1;
	logic [63:0] a_s2;
	logic [47:0] den_s2;

	logic        div_start;
	logic [63:0] div_dividend;
	logic [47:0] div_divisor;
	logic        div_busy;
	logic [63:0] quot;
	logic        sq_busy;
	logic [31:0] root;

	logic              res_valid_q;
	logic [StepOutW-1:0] res_idx_q;
	logic [ResW-1:0]   res_mean_q;
	logic [ResW-1:0]   res_se_q;
	logic              res_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q  <= 7'd64;
			throws_q <= 16'd100;
			blocks_q <= 16'd100;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_STEPS:  steps_q  <= cfg_data[6:0];
				CFG_THROWS: throws_q <= cfg_data;
				CFG_BLOCKS: blocks_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign steps_eff  = (steps_q == 7'd0) ? 7'd1 :
		(steps_q > 7'(MAX_STEPS)) ? 7'(MAX_STEPS) : steps_q;
	assign throws_eff = (throws_q == 16'd0) ? 16'd1 : throws_q;
	assign n_eff      = (blocks_q == 16'd0) ? 16'd1 : blocks_q;

	assign walk_end  = ({1'b0, step_cnt_q} + 7'd1) >= steps_eff;
	assign block_end = ({1'b0, throw_cnt_q} + 17'd1) >= {1'b0, throws_eff};
	assign run_end   = ({1'b0, block_cnt_q} + 17'd1) >= {1'b0, n_eff};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_cnt_q  <= '0;
			throw_cnt_q <= '0;
			block_cnt_q <= '0;
		end else if (cmd.commit) begin
			if (!walk_end) begin
				step_cnt_q <= step_cnt_q + 6'd1;
			end else begin
				step_cnt_q <= '0;
				if (!block_end) begin
					throw_cnt_q <= throw_cnt_q + 16'd1;
				end else begin
					throw_cnt_q <= '0;
					block_cnt_q <= run_end ? 16'd0 : block_cnt_q + 16'd1;
				end
			end
		end
	end

	assign idx     = IW'(step_cnt_q & 6'(MAX_STEPS - 1));
	assign rd_addr = cmd.rd_sample ? idx : ent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '0;
		end else if (cmd.ent_clr) begin
			ent_q <= '0;
		end else if (cmd.ent_inc) begin
			ent_q <= ent_q + IW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_sample) begin
			pos_q <= position;
			idx_q <= idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_vld_q <= '0;
			tot_vld_q <= '0;
		end else begin
			if (cmd.clr_sums) begin
				sum_vld_q <= '0;
			end else if (cmd.commit) begin
				sum_vld_q[idx_q] <= 1'b1;
			end
			if (cmd.clr_tots) begin
				tot_vld_q <= '0;
			end else if (cmd.blk_wr) begin
				tot_vld_q[ent_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		sum_rv_s1 <= sum_vld_q[rd_addr];
		tot_rv_s1 <= tot_vld_q[rd_addr];
	end

	assign sum_eff = sum_rv_s1 ? sum_rdata : 32'd0;
	assign mt_eff  = tot_rv_s1 ? mt_rdata : 32'd0;
	assign sq_eff  = tot_rv_s1 ? sq_rdata : 48'd0;

	bams_ram #(.W(32), .D(MAX_STEPS)) u_sum_ram (
		.clk   (clk),
		.we    (cmd.commit),
		.waddr (idx_q),
		.wdata (sum_eff + {16'd0, pos_q}),
		.raddr (rd_addr),
		.rdata (sum_rdata)
	);

	bams_ram #(.W(32), .D(MAX_STEPS)) u_mt_ram (
		.clk   (clk),
		.we    (cmd.blk_wr),
		.waddr (ent_q),
		.wdata (mt_q),
		.raddr (rd_addr),
		.rdata (mt_rdata)
	);

	bams_ram #(.W(48), .D(MAX_STEPS)) u_sq_ram (
		.clk   (clk),
		.we    (cmd.blk_wr),
		.waddr (ent_q),
		.wdata (sq_q + {16'd0, bmsq_q}),
		.raddr (rd_addr),
		.rdata (sq_rdata)
	);

	assign div_start    = cmd.div_blk || cmd.div_mean || cmd.div_var;
	assign div_dividend = cmd.div_blk ? {32'd0, sum_eff} :
		cmd.div_mean ? {32'd0, mt_eff} : (a_s2 - bsq_s1);
	assign div_divisor  = cmd.div_blk ? {32'd0, throws_eff} :
		cmd.div_mean ? {32'd0, n_eff} : den_s2;

	bams_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.quotient (quot)
	);

	bams_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.sq_start),
		.radicand (quot),
		.busy     (sq_busy),
		.root     (root)
	);

	assign bm = (quot[63:16] != 48'd0) ? 16'hFFFF : quot[15:0];

	always_ff @(posedge clk) begin
		if (cmd.div_blk || cmd.div_mean) begin
			mt_q <= mt_eff;
			sq_q <= sq_eff;
		end else if (cmd.blk_upd) begin
			mt_q <= mt_q + {16'd0, bm};
		end
		if (cmd.blk_upd) begin
			bmsq_q <= {16'd0, bm} * {16'd0, bm};
		end
		if (cmd.mul1) begin
			mean_q <= bm;
			p0_s1  <= {24'd0, n_eff} * {16'd0, sq_q[23:0]};
			p1_s1  <= {24'd0, n_eff} * {16'd0, sq_q[47:24]};
			bsq_s1 <= {32'd0, mt_q} * {32'd0, mt_q};
			nn_s1  <= {16'd0, n_eff} * {16'd0, n_eff};
		end
		if (cmd.mul2) begin
			a_s2   <= {24'd0, p0_s1} + {p1_s1, 24'd0};
			den_s2 <= {16'd0, nn_s1} * {32'd0, n_eff - 16'd1};
		end
		if (cmd.se_zero) begin
			se_q <= '0;
		end else if (cmd.se_load) begin
			se_q <= (root[31:16] != 16'd0) ? 16'hFFFF : root[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_idx_q  <= StepOutW'(ent_q);
			res_mean_q <= mean_q;
			res_se_q   <= se_q;
			res_last_q <= sts.ent_steps;
		end
	end

	assign res_valid       = res_valid_q;
	assign res_step_index  = res_idx_q;
	assign res_mean_value  = res_mean_q;
	assign res_std_error   = res_se_q;
	assign res_last_result = res_last_q;

	assign sts.walk_end  = walk_end;
	assign sts.block_end = block_end;
	assign sts.run_end   = run_end;
	assign sts.ent_max   = (ent_q == IW'(MAX_STEPS - 1));
	assign sts.ent_steps = (ent_q == IW'(steps_eff - 7'd1));
	assign sts.div_busy  = div_busy;
	assign sts.sq_busy   = sq_busy;
	assign sts.var_pos   = (n_eff >= 16'd2) && (a_s2 > bsq_s1);
	assign sts.out_free  = !res_valid_q || res_ready;
endmodule
`default_nettype wire

@@ hw/rtl/block_average_mean_stddev_unit.sv @@
// Top level of the block-average mean and standard error unit.
// Depends on bams_pkg, bams_sample_if, bams_result_if, bams_ctrl and bams_dp.
//
// The sample channel takes walk positions in order, steps_in_use per walk,
// throws_per_block walks per block, block_count blocks per run. Each sample
// is accepted and its step sum read, then the sum plus the position is written
// back. The sample that closes a block starts a pass over all MAX_STEPS step
// entries that divides each sum by the throw count; each entry runs the serial
// divider and adds the block mean and its square to the step totals. If that
// block ends the run, a result pass follows that emits one result per step in
// use: a divider run per step, plus a divider run and square root if var_pos.
// No sample is accepted during either pass. A stalled result holds in the output
// register and the result pass waits for it. Reset clears counters and all
// stored sums and totals through valid bits and loads the register defaults.
// The configuration port writes a register on any cycle with cfg_we high.
`default_nettype none
module block_average_mean_stddev_unit #(
	parameter int MAX_STEPS = 64
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	bams_sample_if.sink                       sample,
	bams_result_if.source                     result,
	input  wire logic                         cfg_we,
	input  wire logic [bams_pkg::CfgIdxW-1:0] cfg_index,
	input  wire logic [bams_pkg::CfgW-1:0]    cfg_data
);
	import bams_pkg::*;

	bams_cmd_t cmd;
	bams_sts_t sts;

	bams_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample.valid),
		.sample_ready (sample.ready),
		.sts          (sts),
		.cmd          (cmd)
	);

	bams_dp #(.MAX_STEPS(MAX_STEPS)) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.position        (sample.position),
		.res_ready       (result.ready),
		.res_valid       (result.valid),
		.res_step_index  (result.step_index),
		.res_mean_value  (result.mean_value),
		.res_std_error   (result.std_error),
		.res_last_result (result.last_result),
		.cmd             (cmd),
		.sts             (sts)
	);
endmodule
`default_nettype wire

@@ hw/rtl/bams_checker.sv @@
// Port-level checks of the block-average unit, bound to the top level.
// Depends on assert_macros.svh and block_average_mean_stddev_unit.
`default_nettype none
`include "assert_macros.svh"
module bams_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_valid,
	input wire logic       s_ready,
	input wire logic       r_valid,
	input wire logic       r_ready,
	input wire logic [5:0] r_step_index,
	input wire logic [15:0] r_mean_value,
	input wire logic [15:0] r_std_error,
	input wire logic       r_last_result
);
	// A stalled result keeps its contents.
	`BAMS_ASSERT_NEXT(a_res_hold, clk, arst_n, r_valid && !r_ready, r_valid && $stable(r_step_index) && $stable(r_mean_value) && $stable(r_std_error) && $stable(r_last_result))

	// An accepted sample is written back before the next one is taken.
	`BAMS_ASSERT_NEXT(a_one_sample, clk, arst_n, s_valid && s_ready, !s_ready)

	// Samples wait while a result pass still has steps to deliver.
	`BAMS_ASSERT_SAME(a_no_sample_mid_run, clk, arst_n, r_valid && !r_last_result, !s_ready)

	// Only the final step of a run can carry the highest index.
	`BAMS_ASSERT_SAME(a_last_index, clk, arst_n, r_valid && !r_last_result, r_step_index != 6'd63)
endmodule

bind block_average_mean_stddev_unit bams_checker u_bams_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_valid       (sample.valid),
	.s_ready       (sample.ready),
	.r_valid       (result.valid),
	.r_ready       (result.ready),
	.r_step_index  (result.step_index),
	.r_mean_value  (result.mean_value),
	.r_std_error   (result.std_error),
	.r_last_result (result.last_result)
);
`default_nettype wire
